[src/stx_etx_lrc_frame_receiver_macros.svh]
// Assertion macros for the STX/ETX LRC frame receiver checker.
// Each macro takes a label, the clock, the active-low reset and the expressions.
`ifndef STX_ETX_LRC_FRAME_RECEIVER_MACROS_SVH
`define STX_ETX_LRC_FRAME_RECEIVER_MACROS_SVH

// same-cycle implication
`define STXR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("frame receiver check failed");

// next-cycle implication
`define STXR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("frame receiver check failed");

`endif

[src/stxetx_pkg.sv]
// Shared types and constants for the STX/ETX LRC frame receiver.
// No dependencies; used by the top level and its port checker.
`timescale 1ns / 1ps

package stxetx_pkg;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_DATA = 2'd1,
    PH_LRC  = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    ST_PENDING  = 3'd0,
    ST_OK       = 3'd1,
    ST_BADLRC   = 3'd2,
    ST_SHORT    = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    CFG_START_CODE = 3'd0,
    CFG_END_CODE   = 3'd1,
    CFG_ACK_CODE   = 3'd2,
    CFG_NAK_CODE   = 3'd3,
    CFG_MIN_LEN    = 3'd4,
    CFG_MAX_LEN    = 3'd5
  } cfg_idx_t;

  localparam int ByteW   = 8;
  localparam int LenW    = 9;
  localparam int CfgIdxW = 3;
  localparam int CfgW    = 9;
  localparam int OutDataW = 32;

  // out_tdata layout, lowest bit up
  localparam int OdByteLo   = 0;
  localparam int OdStatusLo = 8;
  localparam int OdReplyLo  = 11;
  localparam int OdLenLo    = 19;
  localparam int OdUsedW    = 28;

  typedef struct packed {
    logic [LenW-1:0]  frame_length;
    logic [ByteW-1:0] reply_code;
    status_t          frame_status;
    logic             frame_end;
    logic             in_frame;
    logic [ByteW-1:0] out_byte;
  } result_t;

endpackage

[src/stx_etx_lrc_frame_receiver.sv]
// STX/ETX deframer with XOR LRC check: top level.
// Depends on stxetx_pkg.
`timescale 1ns / 1ps
//
// Usage:
//   in_*  : one received byte per beat (in_tdata[7:0]).
//   out_* : one result per input beat: the byte passed through plus frame
//           marking, status, reply code and running frame length.
//   cfg_* : register writes (index 0..5: start, end, ack, nak, min length,
//           max length); cfg_ready is always high. Write only while idle.
// A result goes to the output register, or to the skid stage while a result
// waits there. Throughput: one byte per cycle while in_tready is high; the
// frame state update is a single compare/XOR/increment pass between the
// input handshake and the output register.
// Stall: an output register and a one-entry skid stage hold results, so one
// more byte is taken while a result waits; in_tready falls only when both
// are full and rises again once the receiver takes a beat.
// Reset: rst_n (synchronous, active low) empties both stages, returns to
// hunting for the start code and loads the register defaults
// (2, 3, 6, 21, 5, 256).
module stx_etx_lrc_frame_receiver
  import stxetx_pkg::*;
#(
  parameter int MAX_FRAME = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [ByteW-1:0]    in_tdata,   // [7:0] rx_byte
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OutDataW-1:0] out_tdata,  // [7:0] out_byte, [10:8] frame_status,
                                          // [18:11] reply_code, [27:19] frame_length
  output logic                out_tlast,  // frame_end
  output logic                out_tuser,  // in_frame
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgW-1:0]     cfg_data
);

  // the 9-bit max_frame_len never exceeds 511, so a larger MAX_FRAME caps there
  localparam logic [LenW:0] MaxCap =
    (MAX_FRAME > 511) ? (LenW+1)'(511) : (LenW+1)'(MAX_FRAME);

  logic [ByteW-1:0] start_code_r, end_code_r, ack_code_r, nak_code_r;
  logic [LenW-1:0]  min_len_r, max_len_r;

  phase_t           phase_r, phase_nxt;
  logic [ByteW-1:0] lrc_r, lrc_nxt;
  logic [LenW-1:0]  count_r, count_nxt;

  result_t res;
  result_t out_r, out_nxt, skid_r, skid_nxt;
  logic    out_valid_r, out_valid_nxt, skid_valid_r, skid_valid_nxt;

  logic            in_fire, out_fire;
  logic [LenW:0]   cnt, limit;
  logic [ByteW-1:0] b;

  assign cfg_ready = 1'b1;
  assign in_tready = !skid_valid_r;
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_valid_r && out_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_code_r <= ByteW'(2);
      end_code_r   <= ByteW'(3);
      ack_code_r   <= ByteW'(6);
      nak_code_r   <= ByteW'(21);
      min_len_r    <= LenW'(5);
      max_len_r    <= LenW'(256);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_START_CODE: start_code_r <= cfg_data[ByteW-1:0];
        CFG_END_CODE:   end_code_r   <= cfg_data[ByteW-1:0];
        CFG_ACK_CODE:   ack_code_r   <= cfg_data[ByteW-1:0];
        CFG_NAK_CODE:   nak_code_r   <= cfg_data[ByteW-1:0];
        CFG_MIN_LEN:    min_len_r    <= cfg_data;
        CFG_MAX_LEN:    max_len_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // frame tracking for one byte
  always_comb begin
    b     = in_tdata;
    cnt   = {1'b0, count_r} + (LenW+1)'(1);
    limit = ({1'b0, max_len_r} < MaxCap) ? {1'b0, max_len_r} : MaxCap;

    phase_nxt = phase_r;
    lrc_nxt   = lrc_r;
    count_nxt = count_r;

    res              = '0;
    res.out_byte     = b;
    res.frame_status = ST_PENDING;

    unique case (phase_r) inside
      PH_DATA, PH_LRC: begin
        res.in_frame     = 1'b1;
        res.frame_length = cnt[LenW] ? {LenW{1'b1}} : cnt[LenW-1:0];
        if (cnt > limit) begin
          res.frame_end    = 1'b1;
          res.frame_status = ST_OVERFLOW;
          res.reply_code   = nak_code_r;
          phase_nxt        = PH_HUNT;
          count_nxt        = '0;
          lrc_nxt          = '0;
        end else if (phase_r == PH_DATA) begin
          count_nxt = cnt[LenW-1:0];
          lrc_nxt   = lrc_r ^ b;
          if (b == end_code_r) begin
            phase_nxt = PH_LRC;
          end
        end else begin
          res.frame_end = 1'b1;
          if (cnt < {1'b0, min_len_r}) begin
            res.frame_status = ST_SHORT;
            res.reply_code   = nak_code_r;
          end else if (b == lrc_r) begin
            res.frame_status = ST_OK;
            res.reply_code   = ack_code_r;
          end else begin
            res.frame_status = ST_BADLRC;
            res.reply_code   = nak_code_r;
          end
          phase_nxt = PH_HUNT;
          count_nxt = '0;
          lrc_nxt   = '0;
        end
      end
      default: begin
        phase_nxt = PH_HUNT;
        if (b == start_code_r) begin
          res.in_frame     = 1'b1;
          res.frame_length = LenW'(1);
          lrc_nxt          = '0;
          if (limit == '0) begin
            // limit of zero: the start byte itself overflows
            res.frame_end    = 1'b1;
            res.frame_status = ST_OVERFLOW;
            res.reply_code   = nak_code_r;
            count_nxt        = '0;
          end else begin
            phase_nxt = PH_DATA;
            count_nxt = LenW'(1);
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      lrc_r   <= '0;
      count_r <= '0;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      lrc_r   <= lrc_nxt;
      count_r <= count_nxt;
    end
  end

  // output register and skid stage
  always_comb begin
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (out_fire || !out_valid_r) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        out_nxt       = res;
        out_valid_nxt = in_fire;
      end
    end else if (in_fire) begin
      // hold the waiting beat, park the new one
      skid_nxt       = res;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_r.frame_end;
  assign out_tuser  = out_r.in_frame;
  assign out_tdata  = {(OutDataW-OdUsedW)'(0), out_r.frame_length, out_r.reply_code,
                       out_r.frame_status, out_r.out_byte};

endmodule

[src/stxetx_checker.sv]
// Port-level checker for the STX/ETX LRC frame receiver, with its bind.
// Depends on stxetx_pkg and stx_etx_lrc_frame_receiver_macros.svh.
`timescale 1ns / 1ps
`include "stx_etx_lrc_frame_receiver_macros.svh"

module stxetx_checker
  import stxetx_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                out_tvalid,
  input logic                out_tready,
  input logic [OutDataW-1:0] out_tdata,
  input logic                out_tlast,
  input logic                out_tuser
);

  // a frame end always belongs to a frame
  `STXR_ASSERT_IMP(a_end_in_frame, clk, rst_n, out_tvalid && out_tlast, out_tuser)

  // status and reply stay clear until the frame ends
  `STXR_ASSERT_IMP(a_quiet_mid_frame, clk, rst_n, out_tvalid && !out_tlast,
                   out_tdata[OdLenLo-1:OdStatusLo] == '0)

  // bytes outside a frame carry no length
  `STXR_ASSERT_IMP(a_len_outside, clk, rst_n, out_tvalid && !out_tuser,
                   out_tdata[OdUsedW-1:OdLenLo] == '0)

  // a stalled beat holds
  `STXR_ASSERT_NXT(a_stall_hold, clk, rst_n, out_tvalid && !out_tready,
                   out_tvalid && $stable(out_tdata) && $stable(out_tlast))

endmodule

bind stx_etx_lrc_frame_receiver stxetx_checker u_stxetx_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
